/* rtl/ptss_pkg.sv */
package ptss_pkg;

  // event kinds
  localparam logic [2:0] KIND_CREATE  = 3'd0;
  localparam logic [2:0] KIND_YIELD   = 3'd1;
  localparam logic [2:0] KIND_EXIT    = 3'd2;
  localparam logic [2:0] KIND_START   = 3'd3;
  localparam logic [2:0] KIND_SETPRIO = 3'd4;

  // result status codes
  localparam logic [2:0] STS_OK             = 3'd0;
  localparam logic [2:0] STS_NO_FREE        = 3'd1;
  localparam logic [2:0] STS_ALREADY        = 3'd2;
  localparam logic [2:0] STS_NOTHING_RUN    = 3'd3;
  localparam logic [2:0] STS_ALL_EXITED     = 3'd4;
  localparam logic [2:0] STS_NO_CURRENT     = 3'd5;

  // slot states
  localparam logic [1:0] SLOT_FREE     = 2'd0;
  localparam logic [1:0] SLOT_RUNNABLE = 2'd1;
  localparam logic [1:0] SLOT_RUNNING  = 2'd2;

  localparam logic [1:0] PRIO_MAX  = 2'd2;
  localparam logic [1:0] PRIO_NONE = 2'd3;

  // one candidate slot presented to the pick unit
  typedef struct packed {
    logic       clear;
    logic       en;
    logic       mode_free;
    logic [1:0] cand_state;
    logic [1:0] cand_prio;
  } pick_ctl_t;

endpackage

/* rtl/ptss_pick.sv */
module ptss_pick import ptss_pkg::*; #(
  parameter int IW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  pick_ctl_t     ctl,
  input  logic [IW-1:0] cand_idx,
  output logic          found,
  output logic [IW-1:0] best_idx,
  output logic [1:0]    best_prio
);

  logic take;

  // first free slot, or the runnable slot of highest priority (on a tie the first one wins)
  always_comb begin
    if (ctl.mode_free) begin
      take = (ctl.cand_state == SLOT_FREE) && !found;
    end else begin
      take = (ctl.cand_state == SLOT_RUNNABLE) && (!found || (ctl.cand_prio > best_prio));
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      found <= 1'b0;
    end else if (ctl.en && take) begin
      found <= 1'b1;
    end
    if (ctl.en && take) begin
      best_idx  <= cand_idx;
      best_prio <= ctl.cand_prio;
    end
  end

endmodule

/* rtl/priority_thread_slot_scheduler_top.sv */
// Fixed-priority thread slot scheduler. Each input word is one event (create, yield, exit,
// start, set priority) and gives exactly one result word. Events that search the slot table
// (create, yield, exit, and the first start) walk the slots one per cycle through the single
// read port of the priority RAM and a shared compare unit. They pass through the scan state
// and then the finish state, where the result word is registered once the output is free;
// other events go straight to the finish state. The input is ready again when the result is
// posted. One event is in work at a time. A new event may be accepted while the previous
// result still waits on m_tready. Its result then holds, and the input stays closed, until
// that word is taken.
module priority_thread_slot_scheduler_top import ptss_pkg::*; #(
  parameter int SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // kind[2:0], priority_req[4:3], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status[2:0], created_slot[4:3], switch_happened[5],
                                 // from_slot[8:6], to_slot[10:9], prev_priority[12:11],
                                 // current_priority[14:13], zero fill
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SCAN_END = CW'(SLOTS);
  localparam logic [2:0]    NO_SLOT  = 3'(SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] cnt;

  logic [1:0]    slot_state [SLOTS];
  logic [1:0]    prio_mem [SLOTS];
  logic [1:0]    rd_data;
  logic [IW-1:0] rd_idx;

  logic [IW-1:0] cur_slot;
  logic          cur_valid;
  logic [1:0]    cur_prio;
  logic          started;

  logic [2:0]    ev_kind;
  logic [1:0]    ev_prio;
  logic [2:0]    ev_status;
  logic          ev_scan;
  logic          ev_mode_free;
  logic [2:0]    from_code;

  logic [2:0]    in_kind;
  logic [1:0]    in_prio_raw;
  logic [1:0]    in_prio;
  logic          accept;
  logic [2:0]    acc_status;
  logic          acc_scan;

  pick_ctl_t     pick_ctl;
  logic          found;
  logic [IW-1:0] best_idx;
  logic [1:0]    best_prio;

  logic          fin_fire;
  logic          do_switch;
  logic          do_create;
  logic          do_setp;
  logic          cur_valid_after;
  logic [1:0]    cur_prio_after;
  logic [2:0]    res_status;
  logic [15:0]   res_word;

  assign in_kind     = s_tdata[2:0];
  assign in_prio_raw = s_tdata[4:3];
  assign in_prio     = (in_prio_raw > PRIO_MAX) ? PRIO_MAX : in_prio_raw;
  assign s_tready    = (state == S_IDLE);
  assign accept      = s_tvalid && s_tready;

  // early checks that decide whether the event needs a table walk
  always_comb begin
    acc_status = STS_OK;
    acc_scan   = 1'b0;
    case (in_kind)
      KIND_CREATE: begin
        acc_scan = 1'b1;
      end
      KIND_YIELD, KIND_EXIT: begin
        if (!cur_valid) begin
          acc_status = STS_NO_CURRENT;
        end else begin
          acc_scan = 1'b1;
        end
      end
      KIND_START: begin
        if (started) begin
          acc_status = STS_ALREADY;
        end else begin
          acc_scan = 1'b1;
        end
      end
      KIND_SETPRIO: begin
        if (!cur_valid) begin
          acc_status = STS_NO_CURRENT;
        end
      end
      default: begin
        acc_status = STS_OK;
      end
    endcase
  end

  assign pick_ctl.clear      = accept;
  assign pick_ctl.en         = (state == S_SCAN) && (cnt != '0);
  assign pick_ctl.mode_free  = ev_mode_free;
  assign pick_ctl.cand_state = slot_state[rd_idx];
  assign pick_ctl.cand_prio  = rd_data;

  ptss_pick #(.IW(IW)) u_pick (
    .clk       (clk),
    .rst       (rst),
    .ctl       (pick_ctl),
    .cand_idx  (rd_idx),
    .found     (found),
    .best_idx  (best_idx),
    .best_prio (best_prio)
  );

  assign fin_fire  = (state == S_FIN) && (!m_tvalid || m_tready);
  assign do_switch = ev_scan && !ev_mode_free && found;
  assign do_create = ev_scan && ev_mode_free && found;
  assign do_setp   = (ev_kind == KIND_SETPRIO) && (ev_status == STS_OK);

  assign cur_valid_after = do_switch ? 1'b1 : cur_valid;
  assign cur_prio_after  = do_switch ? best_prio : (do_setp ? ev_prio : cur_prio);

  always_comb begin
    res_status = ev_status;
    if (ev_scan && !found) begin
      if (ev_mode_free) begin
        res_status = STS_NO_FREE;
      end else if (ev_kind == KIND_EXIT) begin
        res_status = STS_ALL_EXITED;
      end else begin
        res_status = STS_NOTHING_RUN;
      end
    end
    res_word        = '0;
    res_word[2:0]   = res_status;
    res_word[4:3]   = do_create ? 2'(best_idx) : 2'd0;
    res_word[5]     = do_switch;
    res_word[8:6]   = do_switch ? from_code : 3'd0;
    res_word[10:9]  = do_switch ? 2'(best_idx) : 2'd0;
    res_word[12:11] = do_setp ? cur_prio : 2'd0;
    res_word[14:13] = cur_valid_after ? cur_prio_after : PRIO_NONE;
  end

  // priority RAM, one read and one write port
  always_ff @(posedge clk) begin
    if (state == S_SCAN && cnt < SCAN_END) begin
      rd_data <= prio_mem[cnt[IW-1:0]];
      rd_idx  <= cnt[IW-1:0];
    end
    if (fin_fire && (do_create || do_setp)) begin
      prio_mem[do_create ? best_idx : cur_slot] <= ev_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      cur_slot  <= '0;
      cur_valid <= 1'b0;
      started   <= 1'b0;
      m_tvalid  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_state[i] <= SLOT_FREE;
      end
    end else begin
      if (fin_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            ev_kind      <= in_kind;
            ev_prio      <= in_prio;
            ev_status    <= acc_status;
            ev_scan      <= acc_scan;
            ev_mode_free <= (in_kind == KIND_CREATE);
            from_code    <= (in_kind == KIND_START && !cur_valid) ? NO_SLOT : 3'(cur_slot);
            cnt          <= '0;
            state        <= acc_scan ? S_SCAN : S_FIN;
            if (acc_scan) begin
              case (in_kind)
                KIND_YIELD: begin
                  slot_state[cur_slot] <= SLOT_RUNNABLE;
                end
                KIND_EXIT: begin
                  slot_state[cur_slot] <= SLOT_FREE;
                  cur_valid            <= 1'b0;
                end
                KIND_START: begin
                  started <= 1'b1;
                end
                default: begin
                end
              endcase
            end
          end
        end
        S_SCAN: begin
          // read of slot cnt overlaps with compare of slot cnt-1
          cnt <= cnt + 1'b1;
          if (cnt == SCAN_END) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            m_tdata  <= res_word;
            state    <= S_IDLE;
            cur_prio <= cur_prio_after;
            if (do_switch) begin
              slot_state[best_idx] <= SLOT_RUNNING;
              cur_slot             <= best_idx;
              cur_valid            <= 1'b1;
            end
            if (do_create) begin
              slot_state[best_idx] <= SLOT_RUNNABLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/ptss_checker.sv */
module ptss_checker import ptss_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // one event at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted again right after an accept");

  // a switch is only reported with ok status
  a_switch_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5] |-> m_tdata[2:0] == STS_OK)
    else $error("switch reported with error status");

  // after a switch there is a current thread with a real priority
  a_switch_prio: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5] |-> m_tdata[14:13] != PRIO_NONE)
    else $error("switch reported without current priority");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind priority_thread_slot_scheduler_top ptss_checker u_ptss_checker (.*);
